### rtl/pet_pkg.sv
// ----------------------------------------------------------------------------
// pet_pkg
// Shared types, codes and saturation helpers for the pointer event tracker.
// ----------------------------------------------------------------------------
package pet_pkg;

    localparam int COORD_BITS = 12;
    localparam int SIZE_W     = 13;
    localparam int VALUE_W    = 16;
    localparam int MASK_W     = 7;
    localparam int CFG_IDX_W  = 2;
    // wide enough for a coordinate plus or minus a delta or a screen size
    localparam int WIDE_W     = ((COORD_BITS > VALUE_W) ? COORD_BITS : VALUE_W) + 2;

    typedef logic [COORD_BITS-1:0]    t_coord;
    typedef logic [SIZE_W-1:0]        t_size;
    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic [MASK_W-1:0]        t_mask;

    localparam t_coord COORD_MAX = {COORD_BITS{1'b1}};

    // input kinds
    localparam logic [2:0] KIND_ABS_X    = 3'd0;
    localparam logic [2:0] KIND_ABS_Y    = 3'd1;
    localparam logic [2:0] KIND_BTN_DOWN = 3'd2;
    localparam logic [2:0] KIND_BTN_UP   = 3'd3;
    localparam logic [2:0] KIND_DELTA_X  = 3'd4;
    localparam logic [2:0] KIND_DELTA_Y  = 3'd5;
    localparam logic [2:0] KIND_WHEEL_Z  = 3'd6;
    localparam logic [2:0] KIND_WHEEL_W  = 3'd7;

    // result kinds
    localparam logic [1:0] EV_PRESS   = 2'd0;
    localparam logic [1:0] EV_RELEASE = 2'd1;
    localparam logic [1:0] EV_MOTION  = 2'd2;

    // buttons
    localparam logic [2:0] BTN_NONE    = 3'd0;
    localparam logic [2:0] BTN_LEFT    = 3'd1;
    localparam logic [2:0] BTN_Z_NEG   = 3'd4;
    localparam logic [2:0] BTN_Z_POS   = 3'd5;
    localparam logic [2:0] BTN_W_NEG   = 3'd6;
    localparam logic [2:0] BTN_W_POS   = 3'd7;

    // rotation codes
    localparam logic [1:0] ROT_NONE = 2'b00;
    localparam logic [1:0] ROT_CW   = 2'b01;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION = 2'd2;

    localparam t_size      RST_WIDTH    = 13'd640;
    localparam t_size      RST_HEIGHT   = 13'd480;
    localparam logic [1:0] RST_ROTATION = ROT_NONE;
    localparam int RST_X_INT = (RST_WIDTH / 2 > t_size'(COORD_MAX)) ? int'(COORD_MAX)
                                                                    : int'(RST_WIDTH / 2);
    localparam int RST_Y_INT = (RST_HEIGHT / 2 > t_size'(COORD_MAX)) ? int'(COORD_MAX)
                                                                     : int'(RST_HEIGHT / 2);
    localparam t_coord RST_CURSOR_X = t_coord'(RST_X_INT);
    localparam t_coord RST_CURSOR_Y = t_coord'(RST_Y_INT);

    typedef struct packed {
        t_size      width;
        t_size      height;
        logic [1:0] rotation;
    } t_cfg;

    // saturate a signed value into 0..hi
    function automatic t_coord sat_to(input t_wide v, input t_coord hi);
        t_coord r;
        if (v[WIDE_W-1]) begin
            r = '0;
        end else if (v > t_wide'(hi)) begin
            r = hi;
        end else begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

    // last valid coordinate for a screen size; zero size acts as size one
    function automatic t_coord bound_of(input t_size size);
        t_coord r;
        if (size == '0) begin
            r = '0;
        end else begin
            r = sat_to(t_wide'(size) - t_wide'(1), COORD_MAX);
        end
        return r;
    endfunction

endpackage

### rtl/pet_ifs.sv
// ----------------------------------------------------------------------------
// pet_ifs
// Valid/ready channels of the pointer event tracker: events, results, config.
// ----------------------------------------------------------------------------
interface pet_evt_if import pet_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [15:0] value;
    logic [7:0]         modifiers;
    logic [31:0]        time_ms;

    modport source (output valid, kind, value, modifiers, time_ms, input ready);
    modport sink   (input valid, kind, value, modifiers, time_ms, output ready);
endinterface

interface pet_res_if import pet_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [2:0]  button;
    t_coord      pos_x;
    t_coord      pos_y;
    t_mask       button_mask;
    logic [7:0]  mod_state;
    logic [31:0] stamp_ms;

    modport source (output valid, event_kind, button, pos_x, pos_y, button_mask,
                    mod_state, stamp_ms, input ready);
    modport sink   (input valid, event_kind, button, pos_x, pos_y, button_mask,
                    mod_state, stamp_ms, output ready);
endinterface

interface pet_cfg_if import pet_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    t_size                data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/pet_rotate.sv
// ----------------------------------------------------------------------------
// pet_rotate
// Maps the cursor to reported coordinates for the display orientation.
// ----------------------------------------------------------------------------
module pet_rotate import pet_pkg::*; (
    input  t_coord i_cur_x,
    input  t_coord i_cur_y,
    input  t_cfg   i_cfg,
    output t_coord o_pos_x,
    output t_coord o_pos_y
);

    t_wide rx;
    t_wide ry;

    always_comb begin
        if (i_cfg.rotation == ROT_NONE) begin
            rx = t_wide'(i_cur_x);
            ry = t_wide'(i_cur_y);
        end else if (i_cfg.rotation == ROT_CW) begin
            rx = t_wide'(i_cur_y);
            ry = t_wide'(i_cfg.width) - t_wide'(i_cur_x) - t_wide'(1);
        end else begin
            // both negative patterns turn counterclockwise
            rx = t_wide'(i_cfg.height) - t_wide'(i_cur_y) - t_wide'(1);
            ry = t_wide'(i_cur_x);
        end
    end

    assign o_pos_x = sat_to(rx, COORD_MAX);
    assign o_pos_y = sat_to(ry, COORD_MAX);

endmodule

### rtl/pointer_event_tracker.sv
// ----------------------------------------------------------------------------
// pointer_event_tracker
// Tracks cursor and held buttons from pointer events, reports rotated results.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                           handshake
//  i_evt    in   kind, value, modifiers, time_ms                   valid/ready
//  o_res    out  event_kind, button, pos_x, pos_y, button_mask,    valid/ready
//                mod_state, stamp_ms
//  i_cfg    in   index, data                                       valid/ready
//
//  One event per cycle while i_evt.ready is high: state and the result in
//  the output register both load at the accepting edge. An event that
//  gives no result just updates state. i_evt.ready drops only while a
//  result waits and o_res.ready is low. Config is always ready. Reset is
//  synchronous, active low, and restores the power-on registers and cursor.
// ----------------------------------------------------------------------------
module pointer_event_tracker import pet_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pet_evt_if.sink   i_evt,
    pet_res_if.source o_res,
    pet_cfg_if.sink   i_cfg
);

    t_cfg   r_cfg;
    t_coord r_x;
    t_coord r_y;
    t_mask  r_held;
    logic   r_out_valid;

    t_coord     n_x;
    t_coord     n_y;
    t_mask      n_held;
    logic       n_emit;
    logic [1:0] n_kind;
    logic [2:0] n_btn;
    t_mask      n_mask;

    logic       accept;
    t_coord     pos_x;
    t_coord     pos_y;
    t_wide      v;

    assign accept      = i_evt.valid && i_evt.ready;
    assign i_evt.ready = !r_out_valid || o_res.ready;
    assign i_cfg.ready = 1'b1;
    assign v           = t_wide'(i_evt.value);

    always_comb begin
        n_x    = r_x;
        n_y    = r_y;
        n_held = r_held;
        n_emit = 1'b1;
        n_kind = EV_MOTION;
        n_btn  = BTN_NONE;
        case (i_evt.kind)
            KIND_ABS_X: begin
                n_x    = sat_to(v, COORD_MAX);
                n_emit = 1'b0;
            end
            KIND_ABS_Y: begin
                // absolute y doubles as a left-button press
                n_y    = sat_to(v, COORD_MAX);
                n_held = t_mask'(1);
                n_kind = EV_PRESS;
                n_btn  = BTN_LEFT;
            end
            KIND_BTN_DOWN, KIND_BTN_UP: begin
                if (i_evt.value >= 16'sd0 && i_evt.value <= 16'sd2) begin
                    n_btn = i_evt.value[2:0] + 3'd1;
                    if (i_evt.kind == KIND_BTN_DOWN) begin
                        n_held = t_mask'(1) << i_evt.value[1:0];
                        n_kind = EV_PRESS;
                    end else begin
                        n_held = '0;
                        n_kind = EV_RELEASE;
                    end
                end else begin
                    n_emit = 1'b0;
                end
            end
            KIND_DELTA_X: begin
                n_x = sat_to(t_wide'(r_x) + v, bound_of(r_cfg.width));
            end
            KIND_DELTA_Y: begin
                // screen y grows downward
                n_y = sat_to(t_wide'(r_y) - v, bound_of(r_cfg.height));
            end
            default: begin
                if (i_evt.value != '0) begin
                    if (i_evt.kind == KIND_WHEEL_Z) begin
                        n_btn = i_evt.value[15] ? BTN_Z_NEG : BTN_Z_POS;
                    end else begin
                        n_btn = i_evt.value[15] ? BTN_W_NEG : BTN_W_POS;
                    end
                    n_held = t_mask'(1) << (n_btn - 3'd1);
                    n_kind = EV_PRESS;
                end
            end
        endcase
        n_mask = (n_kind == EV_MOTION) ? n_held : '0;
    end

    pet_rotate u_rotate (
        .i_cur_x (n_x),
        .i_cur_y (n_y),
        .i_cfg   (r_cfg),
        .o_pos_x (pos_x),
        .o_pos_y (pos_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width    <= RST_WIDTH;
            r_cfg.height   <= RST_HEIGHT;
            r_cfg.rotation <= RST_ROTATION;
            r_x            <= RST_CURSOR_X;
            r_y            <= RST_CURSOR_Y;
            r_held         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_WIDTH:    r_cfg.width    <= i_cfg.data;
                    REG_HEIGHT:   r_cfg.height   <= i_cfg.data;
                    REG_ROTATION: r_cfg.rotation <= i_cfg.data[1:0];
                    default:      ;
                endcase
            end
            if (accept) begin
                r_x         <= n_x;
                r_y         <= n_y;
                r_held      <= n_held;
                r_out_valid <= n_emit;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted event that gives a result
    logic [1:0]  r_kind;
    logic [2:0]  r_btn;
    t_coord      r_pos_x;
    t_coord      r_pos_y;
    t_mask       r_mask;
    logic [7:0]  r_mod;
    logic [31:0] r_stamp;

    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_kind  <= n_kind;
            r_btn   <= n_btn;
            r_pos_x <= pos_x;
            r_pos_y <= pos_y;
            r_mask  <= n_mask;
            r_mod   <= i_evt.modifiers;
            r_stamp <= i_evt.time_ms;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.event_kind  = r_kind;
    assign o_res.button      = r_btn;
    assign o_res.pos_x       = r_pos_x;
    assign o_res.pos_y       = r_pos_y;
    assign o_res.button_mask = r_mask;
    assign o_res.mod_state   = r_mod;
    assign o_res.stamp_ms    = r_stamp;

`ifndef SYNTHESIS
    a_held_onehot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_held))
        else $error("held button mask has more than one bit");

    a_button_no_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.event_kind != EV_MOTION |-> o_res.button_mask == '0)
        else $error("button result carries a held mask");

    a_motion_no_button: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.event_kind == EV_MOTION |-> o_res.button == BTN_NONE)
        else $error("motion result carries a button");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid right after reset");
`endif

endmodule

### verif/tb_pointer_event_tracker.sv
// ----------------------------------------------------------------------------
// tb_pointer_event_tracker
// Self-checking bench for the pointer event tracker. A driver feeds words from
// a queue of pointer events and tracks cursor, held buttons and screen setup
// in a local copy. Each accepted event queues the report it should cause, and
// a monitor compares every report word field by field. Both channels idle at
// random, and the screen setup is changed between bursts, including the
// extreme sizes and every rotation pattern.
// ----------------------------------------------------------------------------
module tb_pointer_event_tracker;
    import pet_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    LIMIT_CYCLES = 1000000;
    localparam int    BURST_EVENTS = 210;
    // rotation patterns beyond the package codes, as sign-extended register data
    localparam t_size CFG_ROT_CCW  = {SIZE_W{1'b1}};
    localparam t_size CFG_ROT_CCW2 = CFG_ROT_CCW - t_size'(1);

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [15:0] value;
        logic [7:0]         mods;
        logic [31:0]        stamp;
    } ptr_event_t;

    typedef struct packed {
        logic [1:0]  ev;
        logic [2:0]  btn;
        t_coord      x;
        t_coord      y;
        t_mask       mask;
        logic [7:0]  mods;
        logic [31:0] stamp;
    } report_t;

    logic i_clk;
    logic i_rst_n;

    pet_evt_if evt();
    pet_res_if res();
    pet_cfg_if cfg();

    pointer_event_tracker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    // tracked state of the block
    t_size      scr_w   = 13'd640;
    t_size      scr_h   = 13'd480;
    logic [1:0] scr_rot = ROT_NONE;
    t_coord     cur_x   = 12'd320;
    t_coord     cur_y   = 12'd240;
    t_mask      held    = '0;

    ptr_event_t queued_events[$];
    report_t    pending_reports[$];
    ptr_event_t on_bus;
    report_t    next_due;
    int         queued_total = 0;
    int         taken_total  = 0;
    int         errors       = 0;
    int         cycles       = 0;
    int         gap_left     = 0;
    int         hold_left    = 0;
    bit         idle_on      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_coord clip(input int v, input int hi);
        if (v < 0) return '0;
        if (v > hi) return t_coord'(hi);
        return t_coord'(v);
    endfunction

    function automatic int last_pixel(input t_size s);
        int b;
        b = (s == '0) ? 0 : int'(s) - 1;
        return (b > int'(COORD_MAX)) ? int'(COORD_MAX) : b;
    endfunction

    function automatic void post_report(input logic [1:0] ev, input logic [2:0] btn,
                                        input t_mask mask, input ptr_event_t e);
        report_t r;
        int      rx;
        int      ry;
        if (scr_rot == ROT_NONE) begin
            rx = int'(cur_x);
            ry = int'(cur_y);
        end else if (!scr_rot[1]) begin
            rx = int'(cur_y);
            ry = int'(scr_w) - int'(cur_x) - 1;
        end else begin
            rx = int'(scr_h) - int'(cur_y) - 1;
            ry = int'(cur_x);
        end
        r.ev    = ev;
        r.btn   = btn;
        r.x     = clip(rx, int'(COORD_MAX));
        r.y     = clip(ry, int'(COORD_MAX));
        r.mask  = mask;
        r.mods  = e.mods;
        r.stamp = e.stamp;
        pending_reports.push_back(r);
    endfunction

    // update the tracked cursor and buttons for one accepted event
    function automatic void track_event(input ptr_event_t e);
        int         v;
        logic [2:0] btn;
        v = int'(e.value);
        case (e.kind)
            KIND_ABS_X: begin
                cur_x = clip(v, int'(COORD_MAX));
            end
            KIND_ABS_Y: begin
                cur_y = clip(v, int'(COORD_MAX));
                held  = t_mask'(1);
                post_report(EV_PRESS, BTN_LEFT, '0, e);
            end
            KIND_BTN_DOWN, KIND_BTN_UP: begin
                if (v >= 0 && v <= 2) begin
                    btn = 3'(v + 1);
                    if (e.kind == KIND_BTN_DOWN) begin
                        held = t_mask'(1) << (btn - 1);
                        post_report(EV_PRESS, btn, '0, e);
                    end else begin
                        held = '0;
                        post_report(EV_RELEASE, btn, '0, e);
                    end
                end
            end
            KIND_DELTA_X: begin
                cur_x = clip(int'(cur_x) + v, last_pixel(scr_w));
                post_report(EV_MOTION, BTN_NONE, held, e);
            end
            KIND_DELTA_Y: begin
                // screen y grows downward, so invert the move
                cur_y = clip(int'(cur_y) - v, last_pixel(scr_h));
                post_report(EV_MOTION, BTN_NONE, held, e);
            end
            default: begin
                if (v == 0) begin
                    post_report(EV_MOTION, BTN_NONE, held, e);
                end else begin
                    if (e.kind == KIND_WHEEL_Z) btn = (v < 0) ? BTN_Z_NEG : BTN_Z_POS;
                    else btn = (v < 0) ? BTN_W_NEG : BTN_W_POS;
                    held = t_mask'(1) << (btn - 1);
                    post_report(EV_PRESS, btn, '0, e);
                end
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic ptr_event_t mk_event(input logic [2:0] kind, input int value);
        ptr_event_t e;
        e.kind  = kind;
        e.value = 16'(value);
        e.mods  = 8'($urandom);
        e.stamp = $urandom;
        return e;
    endfunction

    function automatic ptr_event_t rand_event();
        logic [2:0] kind;
        int         r;
        int         v;
        kind = 3'($urandom_range(0, 7));
        r    = $urandom_range(0, 99);
        if ((kind == KIND_BTN_DOWN || kind == KIND_BTN_UP) && r < 80) begin
            v = $urandom_range(0, 2);
        end else if (r < 35) begin
            v = int'($urandom_range(0, 64)) - 32;
        end else if (r < 60) begin
            // positions around every screen edge, some past the coordinate range
            v = $urandom_range(0, 4600);
        end else if (r < 80) begin
            v = int'($signed(16'($urandom)));
        end else begin
            case ($urandom_range(0, 3))
                0: v = -32768;
                1: v = 32767;
                2: v = 0;
                default: v = -1;
            endcase
        end
        return mk_event(kind, v);
    endfunction

    function automatic void push_event(input ptr_event_t e);
        queued_events.push_back(e);
        queued_total++;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_size data);
        @(posedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge i_clk); while (cfg.ready !== 1'b1);
        cfg.valid <= 1'b0;
        case (idx)
            REG_WIDTH:    scr_w = data;
            REG_HEIGHT:   scr_h = data;
            REG_ROTATION: scr_rot = data[1:0];
            default: ;
        endcase
    endtask

    task automatic set_screen(input t_size w, input t_size h, input t_size rot);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_ROTATION, rot);
    endtask

    // wait until every event is taken and every report is checked
    task automatic drain();
        while (taken_total != queued_total || pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_burst(input int n, input bit idle);
        idle_on = idle;
        repeat (n) push_event(rand_event());
        drain();
    endtask

    function automatic t_size rand_rot();
        case ($urandom_range(0, 3))
            0: return t_size'(ROT_NONE);
            1: return t_size'(ROT_CW);
            2: return CFG_ROT_CCW;
            default: return CFG_ROT_CCW2;
        endcase
    endfunction

    // event driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            evt.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (evt.valid && evt.ready) begin
                track_event(on_bus);
                taken_total++;
            end
            if (!evt.valid || evt.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    evt.valid <= 1'b0;
                end else if (queued_events.size() > 0) begin
                    on_bus = queued_events.pop_front();
                    evt.valid     <= 1'b1;
                    evt.kind      <= on_bus.kind;
                    evt.value     <= on_bus.value;
                    evt.modifiers <= on_bus.mods;
                    evt.time_ms   <= on_bus.stamp;
                    gap_left = idle_on ? pick_gap() : 0;
                end else begin
                    evt.valid <= 1'b0;
                end
            end
        end
    end

    // report monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (res.valid && res.ready) begin
                if (pending_reports.size() == 0) begin
                    $error("report word with nothing pending: kind %0d button %0d",
                           res.event_kind, res.button);
                    errors++;
                end else begin
                    next_due = pending_reports.pop_front();
                    check_field("event_kind", 32'(next_due.ev), 32'(res.event_kind));
                    check_field("button", 32'(next_due.btn), 32'(res.button));
                    check_field("pos_x", 32'(next_due.x), 32'(res.pos_x));
                    check_field("pos_y", 32'(next_due.y), 32'(res.pos_y));
                    check_field("button_mask", 32'(next_due.mask), 32'(res.button_mask));
                    check_field("mod_state", 32'(next_due.mods), 32'(res.mod_state));
                    check_field("stamp_ms", next_due.stamp, res.stamp_ms);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                res.ready <= 1'b0;
            end else begin
                res.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 2) == 0) hold_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb_pointer_event_tracker NOT OK");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        evt.valid     = 1'b0;
        evt.kind      = KIND_ABS_X;
        evt.value     = '0;
        evt.modifiers = '0;
        evt.time_ms   = '0;
        res.ready     = 1'b0;
        cfg.valid     = 1'b0;
        cfg.index     = REG_WIDTH;
        cfg.data      = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed events on the power-on screen
        push_event(mk_event(KIND_DELTA_X, 0));
        push_event(mk_event(KIND_ABS_X, 32767));
        push_event(mk_event(KIND_ABS_X, -32768));
        push_event(mk_event(KIND_ABS_X, 100));
        push_event(mk_event(KIND_ABS_Y, 5000));
        push_event(mk_event(KIND_ABS_Y, -5));
        push_event(mk_event(KIND_ABS_Y, 200));
        for (int b = 0; b < 3; b++) begin
            push_event(mk_event(KIND_BTN_DOWN, b));
            push_event(mk_event(KIND_BTN_UP, b));
        end
        push_event(mk_event(KIND_BTN_DOWN, 3));
        push_event(mk_event(KIND_BTN_DOWN, -1));
        push_event(mk_event(KIND_BTN_UP, 32767));
        push_event(mk_event(KIND_DELTA_X, 32767));
        push_event(mk_event(KIND_DELTA_X, -32768));
        push_event(mk_event(KIND_DELTA_Y, 1));
        push_event(mk_event(KIND_DELTA_Y, -32768));
        push_event(mk_event(KIND_DELTA_Y, 32767));
        push_event(mk_event(KIND_WHEEL_Z, -1));
        push_event(mk_event(KIND_WHEEL_Z, 1));
        push_event(mk_event(KIND_WHEEL_Z, 0));
        push_event(mk_event(KIND_WHEEL_W, -32768));
        push_event(mk_event(KIND_WHEEL_W, 32767));
        push_event(mk_event(KIND_WHEEL_W, 0));
        // park the cursor off screen, then pull it back with a null move
        push_event(mk_event(KIND_ABS_X, 4000));
        push_event(mk_event(KIND_ABS_Y, 3000));
        push_event(mk_event(KIND_DELTA_X, 0));
        push_event(mk_event(KIND_DELTA_Y, 0));
        drain();

        run_burst(BURST_EVENTS, 1'b1);
        set_screen(13'd1, 13'd1, t_size'(ROT_CW));
        run_burst(BURST_EVENTS, 1'b1);
        set_screen(13'd4096, 13'd4096, CFG_ROT_CCW);
        run_burst(BURST_EVENTS, 1'b0);
        set_screen({SIZE_W{1'b1}}, '0, CFG_ROT_CCW2);
        run_burst(BURST_EVENTS, 1'b1);
        set_screen('0, {SIZE_W{1'b1}}, t_size'(ROT_NONE));
        run_burst(BURST_EVENTS, 1'b1);
        set_screen(13'd640, 13'd480, t_size'(ROT_CW));
        run_burst(BURST_EVENTS, 1'b0);
        set_screen(13'd100, 13'd50, CFG_ROT_CCW);
        run_burst(BURST_EVENTS, 1'b1);
        set_screen(t_size'($urandom_range(1, 4096)), t_size'($urandom_range(1, 4096)),
                   rand_rot());
        run_burst(BURST_EVENTS, 1'b1);

        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_pointer_event_tracker OK");
        end else begin
            $display("tb_pointer_event_tracker NOT OK");
        end
        $finish;
    end

endmodule
